// ===== design/mbps_pkg.sv =====
`timescale 1ns / 1ps
// shared types, constants and helpers for the masked byte pattern scanner
package mbps_pkg;

   localparam int MAX_PATTERN   = 32;
   localparam int PATTERN_BYTES = 32;
   localparam int USABLE_LENGTH = (MAX_PATTERN < PATTERN_BYTES) ? MAX_PATTERN : PATTERN_BYTES;
   localparam int PATTERN_WORDS = PATTERN_BYTES / 8;
   localparam int CSR_INDEX_W   = 3;
   localparam int CSR_DATA_W    = 64;
   localparam int POS_W         = 32;
   localparam int LEN_W         = 6;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_PATTERN_WORD_0 = 3'd0,
      CSR_PATTERN_WORD_1 = 3'd1,
      CSR_PATTERN_WORD_2 = 3'd2,
      CSR_PATTERN_WORD_3 = 3'd3,
      CSR_CARE_MASK      = 3'd4,
      CSR_PATTERN_LENGTH = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic [1:0]       match_count;
      logic [POS_W-1:0] first_offset;
      logic             too_long;
   } rsp_type;

   // one accepted byte as seen by the tally
   typedef struct packed {
      logic accept;
      logic last;
      logic hit;
   } mbps_step_type;

   function automatic logic [7:0] get_pattern_byte(
      input logic [PATTERN_WORDS-1:0][63:0] words,
      input logic [4:0]                     j
   );
      return words[j[4:3]][{j[2:0], 3'b000} +: 8];
   endfunction

endpackage

// ===== design/mbps_cell.sv =====
`timescale 1ns / 1ps
// one window cell: holds a byte, passes it on, compares the incoming byte
module mbps_cell
   import mbps_pkg::*;
(
   input  logic       clock,
   input  logic       shift_en,
   input  logic [7:0] shift_byte,
   input  logic [7:0] pattern_byte,
   input  logic       must_match,
   output logic [7:0] byte_out,
   output logic       byte_ok
);

   logic [7:0] byte_ff;
   logic [7:0] byte_in;

   assign byte_in = shift_en ? shift_byte : byte_ff;

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
   end

   assign byte_out = byte_ff;
   assign byte_ok  = !must_match || (shift_byte == pattern_byte);

endmodule

// ===== design/mbps_tally.sv =====
`timescale 1ns / 1ps
// per-region position, hit count, first offset and the result register
module mbps_tally
   import mbps_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  mbps_step_type    step,
   input  logic [LEN_W-1:0] pattern_length,
   input  logic             rsp_ready,
   output logic             pos_full,
   output logic             req_ready,
   output logic             rsp_valid,
   output rsp_type          rsp_data
);

   logic [POS_W-1:0] pos_ff, pos_in;
   logic [1:0]       hit_count_ff, hit_count_in;
   logic [POS_W-1:0] first_ff, first_in;
   logic             ovf_ff, ovf_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_data_ff, rsp_data_in;
   logic [POS_W-1:0] count;
   logic             counted_hit;

   assign pos_full    = (pos_ff == {POS_W{1'b1}});
   assign count       = pos_ff + POS_W'(1);
   assign counted_hit = step.hit && (count >= POS_W'(pattern_length));
   assign req_ready   = !rsp_valid_ff || rsp_ready;

   always_comb begin
      pos_in       = pos_ff;
      hit_count_in = hit_count_ff;
      first_in     = first_ff;
      ovf_in       = ovf_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      if (step.accept) begin
         if (pos_full) begin
            ovf_in = 1'b1;
         end else begin
            pos_in = count;
            if (counted_hit) begin
               if (hit_count_ff == 2'd0) begin
                  first_in = count - POS_W'(pattern_length);
               end
               if (hit_count_ff != 2'd2) begin
                  hit_count_in = hit_count_ff + 2'd1;
               end
            end
         end
         if (step.last) begin
            rsp_valid_in             = 1'b1;
            rsp_data_in.match_count  = hit_count_in;
            rsp_data_in.first_offset = (hit_count_in != 2'd0) ? first_in : '0;
            rsp_data_in.too_long     = ovf_in;
            pos_in       = '0;
            hit_count_in = '0;
            first_in     = '0;
            ovf_in       = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         hit_count_ff <= '0;
         first_ff     <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pos_ff       <= pos_in;
         hit_count_ff <= hit_count_in;
         first_ff     <= first_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_no_accept_when_blocked: assert property (@(posedge clock) disable iff (reset)
      step.accept |-> (!rsp_valid_ff || rsp_ready))
      else $error("byte transfer while result register is blocked");

   a_last_gives_result: assert property (@(posedge clock) disable iff (reset)
      (step.accept && step.last) |=> rsp_valid_ff)
      else $error("final byte did not load the result register");

   a_offset_clear_without_hits: assert property (@(posedge clock) disable iff (reset)
      (hit_count_ff == 2'd0) |-> (first_ff == '0))
      else $error("first offset set with no hits");

   a_hit_count_range: assert property (@(posedge clock) disable iff (reset)
      hit_count_ff != 2'd3)
      else $error("hit count beyond saturation");

endmodule

// ===== design/masked_byte_pattern_scanner_top.sv =====
`timescale 1ns / 1ps
// Masked byte pattern scanner: takes one byte per cycle into a 32-cell shift
// chain, each cell comparing its incoming byte against the care-masked pattern
// byte aligned to it, so a whole window compare and the hit tally finish in
// the cycle the byte is transferred. The result for a region is registered and
// shows on rsp in the cycle after the final byte; bytes keep flowing while it
// waits, and input is held off only when that result register is full and the
// receiver is not taking it. Registers may be written any time no result is
// pending; a write takes effect for the next byte.
module masked_byte_pattern_scanner_top
   import mbps_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  req_type                req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output rsp_type                rsp_data,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   logic [PATTERN_WORDS-1:0][63:0] pattern_ff;
   logic [PATTERN_BYTES-1:0]       care_ff;
   logic [LEN_W-1:0]               length_ff;

   logic                           accept;
   logic                           pos_full;
   logic                           shift_en;
   logic                           len_ok;
   logic                           all_ok;
   mbps_step_type                  step;

   logic [MAX_PATTERN-1:0][6:0]    lane_diff;
   logic [MAX_PATTERN-1:0][7:0]    lane_pattern;
   logic [MAX_PATTERN-1:0]         lane_must;
   logic [MAX_PATTERN-1:0][7:0]    win;
   logic [MAX_PATTERN-1:0]         lane_ok;

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_ff <= '0;
         care_ff    <= '0;
         length_ff  <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_PATTERN_WORD_0: pattern_ff[0] <= csr_wdata;
            CSR_PATTERN_WORD_1: pattern_ff[1] <= csr_wdata;
            CSR_PATTERN_WORD_2: pattern_ff[2] <= csr_wdata;
            CSR_PATTERN_WORD_3: pattern_ff[3] <= csr_wdata;
            CSR_CARE_MASK:      care_ff       <= csr_wdata[PATTERN_BYTES-1:0];
            CSR_PATTERN_LENGTH: length_ff     <= csr_wdata[LEN_W-1:0];
            default: ;
         endcase
      end
   end

   assign len_ok = (length_ff != '0) && ({1'b0, length_ff} <= 7'(USABLE_LENGTH));

   // cell k compares the byte k transfers back and meets pattern byte length-1-k
   always_comb begin
      for (int k = 0; k < MAX_PATTERN; k++) begin
         lane_diff[k]    = {1'b0, length_ff} - 7'(k) - 7'd1;
         lane_pattern[k] = get_pattern_byte(pattern_ff, lane_diff[k][4:0]);
         lane_must[k]    = len_ok && !lane_diff[k][6] && care_ff[lane_diff[k][4:0]];
      end
   end

   assign accept   = req_valid && req_ready;
   assign shift_en = accept && !pos_full;

   for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
      mbps_cell u_cell (
         .clock        (clock),
         .shift_en     (shift_en),
         .shift_byte   ((k == 0) ? req_data.data_byte : win[(k == 0) ? 0 : k - 1]),
         .pattern_byte (lane_pattern[k]),
         .must_match   (lane_must[k]),
         .byte_out     (win[k]),
         .byte_ok      (lane_ok[k])
      );
   end

   assign all_ok = &lane_ok;

   assign step.accept = accept;
   assign step.last   = req_data.last_byte;
   assign step.hit    = len_ok && all_ok;

   mbps_tally u_tally (
      .clock          (clock),
      .reset          (reset),
      .step           (step),
      .pattern_length (length_ff),
      .rsp_ready      (rsp_ready),
      .pos_full       (pos_full),
      .req_ready      (req_ready),
      .rsp_valid      (rsp_valid),
      .rsp_data       (rsp_data)
   );

endmodule
